/* design/iafp_pkg.sv */
// ---------------------------------------------------------------------------
// iafp_pkg
// Shared types and constants for the yaw frame parser and moving average.
// ---------------------------------------------------------------------------
package iafp_pkg;

   localparam int WINDOW_DEPTH = 8;
   localparam int DEPTH_LOG2   = $clog2(WINDOW_DEPTH);
   localparam int YAW_WIDTH    = 16;
   localparam int SUM_WIDTH    = YAW_WIDTH + DEPTH_LOG2;

   localparam logic [7:0] HDR_FIRST  = 8'h55;
   localparam logic [7:0] HDR_SECOND = 8'h53;

   typedef enum logic [2:0] {
      POS_HDR_FIRST  = 3'd0,
      POS_HDR_SECOND = 3'd1,
      POS_SKIP_0     = 3'd2,
      POS_SKIP_1     = 3'd3,
      POS_SKIP_2     = 3'd4,
      POS_SKIP_3     = 3'd5,
      POS_YAW_LOW    = 3'd6,
      POS_YAW_HIGH   = 3'd7
   } frame_pos_type;

   typedef logic signed [YAW_WIDTH-1:0] yaw_type;

   typedef struct packed {
      logic    vld;
      yaw_type yaw;
   } yaw_sample_type;

endpackage

/* design/iafp_frame_parser.sv */
// ---------------------------------------------------------------------------
// iafp_frame_parser
// Header hunt and yaw word capture; holds one parsed sample until taken.
// ---------------------------------------------------------------------------
module iafp_frame_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    byte_accept,
   input  logic [7:0]              rx_byte,
   input  logic                    sample_take,
   output iafp_pkg::yaw_sample_type sample
);

   iafp_pkg::frame_pos_type pos_ff, pos_in;
   logic [7:0]              low_ff, low_in;
   logic                    vld_ff, vld_in;
   iafp_pkg::yaw_type       yaw_ff, yaw_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= iafp_pkg::POS_HDR_FIRST;
         low_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         low_ff <= low_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      yaw_ff <= yaw_in;
   end

   always_comb begin
      pos_in = pos_ff;
      low_in = low_ff;
      vld_in = vld_ff & ~sample_take;
      yaw_in = yaw_ff;
      if (byte_accept) begin
         unique case (pos_ff)
            iafp_pkg::POS_HDR_FIRST:
               pos_in = (rx_byte == iafp_pkg::HDR_FIRST) ? iafp_pkg::POS_HDR_SECOND
                                                         : iafp_pkg::POS_HDR_FIRST;
            // mismatch restarts the hunt without rechecking this byte
            iafp_pkg::POS_HDR_SECOND:
               pos_in = (rx_byte == iafp_pkg::HDR_SECOND) ? iafp_pkg::POS_SKIP_0
                                                          : iafp_pkg::POS_HDR_FIRST;
            iafp_pkg::POS_SKIP_0:  pos_in = iafp_pkg::POS_SKIP_1;
            iafp_pkg::POS_SKIP_1:  pos_in = iafp_pkg::POS_SKIP_2;
            iafp_pkg::POS_SKIP_2:  pos_in = iafp_pkg::POS_SKIP_3;
            iafp_pkg::POS_SKIP_3:  pos_in = iafp_pkg::POS_YAW_LOW;
            iafp_pkg::POS_YAW_LOW: begin
               low_in = rx_byte;
               pos_in = iafp_pkg::POS_YAW_HIGH;
            end
            iafp_pkg::POS_YAW_HIGH: begin
               yaw_in = {rx_byte, low_ff};
               vld_in = 1'b1;
               pos_in = iafp_pkg::POS_HDR_FIRST;
            end
            default: pos_in = iafp_pkg::POS_HDR_FIRST;
         endcase
      end
   end

   assign sample.vld = vld_ff;
   assign sample.yaw = yaw_ff;

   // a new sample only appears on the high byte, which ends the frame
   a_sample_ends_frame: assert property (@(posedge clock) disable iff (reset)
      $rose(vld_ff) |-> pos_ff == iafp_pkg::POS_HDR_FIRST)
      else $error("sample raised without returning to header hunt");

endmodule

/* design/iafp_window_cell.sv */
// ---------------------------------------------------------------------------
// iafp_window_cell
// One window slot; takes its neighbor's sample on each push.
// ---------------------------------------------------------------------------
module iafp_window_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  iafp_pkg::yaw_type sample_in,
   output iafp_pkg::yaw_type sample_out
);

   iafp_pkg::yaw_type sample_ff, sample_in_d;

   assign sample_in_d = shift_en ? sample_in : sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in_d;
      end
   end

   assign sample_out = sample_ff;

endmodule

/* design/iafp_window_chain.sv */
// ---------------------------------------------------------------------------
// iafp_window_chain
// Row of window cells with running sum; gives the floored mean including the sample being pushed.
// ---------------------------------------------------------------------------
module iafp_window_chain (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  iafp_pkg::yaw_type sample,
   output iafp_pkg::yaw_type mean
);

   iafp_pkg::yaw_type cell_q [iafp_pkg::WINDOW_DEPTH];

   logic signed [iafp_pkg::SUM_WIDTH-1:0] sum_ff, sum_in, sum_next;

   for (genvar i = 0; i < iafp_pkg::WINDOW_DEPTH; i++) begin : g_cell
      iafp_window_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (push),
         .sample_in  ((i == 0) ? sample : cell_q[(i == 0) ? 0 : i-1]),
         .sample_out (cell_q[i])
      );
   end

   // oldest sample falls off the end of the row
   assign sum_next = sum_ff
                   - iafp_pkg::SUM_WIDTH'(cell_q[iafp_pkg::WINDOW_DEPTH-1])
                   + iafp_pkg::SUM_WIDTH'(sample);
   assign sum_in   = push ? sum_next : sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   // arithmetic shift by log2 depth, floored; result always fits 16 bits
   assign mean = sum_next[iafp_pkg::DEPTH_LOG2 +: iafp_pkg::YAW_WIDTH];

   a_sum_holds: assert property (@(posedge clock) disable iff (reset)
      !$past(push) && !$past(reset) |-> $stable(sum_ff))
      else $error("window sum changed without a push");

endmodule

/* design/imu_angle_frame_parser_moving_average_core.sv */
// ---------------------------------------------------------------------------
// imu_angle_frame_parser_moving_average_core
// Parses yaw from sensor frames and outputs raw yaw plus window mean.
// ---------------------------------------------------------------------------
// The yaw word from the high byte passes the parsed-sample register, then the output register, before rsp_tvalid.
// Throughput: one byte per cycle unless both registers are full; the parsed-sample register and the output
// register let a new byte in while a result waits on rsp_tready.
// Reset: synchronous; returns to header hunt and clears all window cells and
// the running sum in the same cycle.
module imu_angle_frame_parser_moving_average_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [15:0] yaw_latest, [31:16] yaw_mean
);

   iafp_pkg::yaw_sample_type sample;
   iafp_pkg::yaw_type        mean;
   iafp_pkg::yaw_type        yaw_out_ff, yaw_out_in, mean_out_ff, mean_out_in;
   logic                     rsp_vld_ff, rsp_vld_in;
   logic                     out_free, push, byte_accept;

   assign out_free    = ~rsp_vld_ff | rsp_tready;
   assign push        = sample.vld & out_free;
   assign req_tready  = ~sample.vld | out_free;
   assign byte_accept = req_tvalid & req_tready;

   iafp_frame_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .rx_byte     (req_tdata),
      .sample_take (push),
      .sample      (sample)
   );

   iafp_window_chain u_chain (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .sample (sample.yaw),
      .mean   (mean)
   );

   assign rsp_vld_in  = push | (rsp_vld_ff & ~rsp_tready);
   assign yaw_out_in  = push ? sample.yaw : yaw_out_ff;
   assign mean_out_in = push ? mean : mean_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      yaw_out_ff  <= yaw_out_in;
      mean_out_ff <= mean_out_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {mean_out_ff, yaw_out_ff};

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && sample.vld)
      else $error("input stalled with a free output register");

   a_rsp_from_sample: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(sample.vld))
      else $error("result raised without a parsed sample");

endmodule

/* tb/sv/imu_angle_frame_parser_moving_average_core_tb.sv */
// ---------------------------------------------------------------------------
// imu_angle_frame_parser_moving_average_core_tb
// Drives sensor bytes into the yaw frame parser and checks each raw yaw and
// window mean against the directed table or an in-bench frame parser and running-sum model.
// ---------------------------------------------------------------------------
module imu_angle_frame_parser_moving_average_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BYTES = 1800;
   localparam int HOLD_AFTER   = 600;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int NUM_DIR      = 20;

   // rsp_tdata layout: [15:0] yaw_latest, [31:16] yaw_mean
   typedef struct packed {
      iafp_pkg::yaw_type yaw_mean;
      iafp_pkg::yaw_type yaw_latest;
   } yaw_result_type;

   typedef struct packed {
      logic [7:0]     rx;
      logic           has_exp;
      yaw_result_type res;
   } dir_row_type;

   // header mismatch cases, then a frame at each yaw extreme
   localparam dir_row_type DIR_ROWS [NUM_DIR] = '{
      '{8'h00, 1'b0, '0},
      '{8'h55, 1'b0, '0},
      '{8'h55, 1'b0, '0},   // second header wrong, not rechecked as first
      '{8'h53, 1'b0, '0},   // first header wrong, stays hunting
      '{8'h55, 1'b0, '0},
      '{8'h53, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h55, 1'b0, '0},
      '{8'h53, 1'b0, '0},   // skipped bytes are not examined
      '{8'hFF, 1'b0, '0},
      '{8'h7F, 1'b1, '{16'sd4095, 16'sd32767}},
      '{8'h55, 1'b0, '0},
      '{8'h53, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h80, 1'b1, '{-16'sd1, 16'sh8000}}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   imu_angle_frame_parser_moving_average_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser and window state
   iafp_pkg::frame_pos_type                 frame_pos = iafp_pkg::POS_HDR_FIRST;
   logic [7:0]                              low_byte  = '0;
   iafp_pkg::yaw_type                       yaw_window [iafp_pkg::WINDOW_DEPTH];
   logic [iafp_pkg::DEPTH_LOG2-1:0]         win_idx   = '0;
   logic signed [iafp_pkg::SUM_WIDTH-1:0]   yaw_sum   = '0;

   yaw_result_type expected_results [$];
   int             error_count = 0;
   int             bytes_sent  = 0;
   int             burst_left  = 0;
   int             cycle_count = 0;
   bit             hold_done   = 1'b0;

   initial begin
      for (int i = 0; i < iafp_pkg::WINDOW_DEPTH; i++) yaw_window[i] = '0;
   end

   function automatic bit parse_byte(input logic [7:0] b, output yaw_result_type res);
      iafp_pkg::yaw_type                     yaw;
      logic signed [iafp_pkg::SUM_WIDTH-1:0] shifted;
      res = '0;
      case (frame_pos)
         iafp_pkg::POS_HDR_FIRST: begin
            frame_pos = (b == iafp_pkg::HDR_FIRST) ? iafp_pkg::POS_HDR_SECOND
                                                   : iafp_pkg::POS_HDR_FIRST;
            return 1'b0;
         end
         iafp_pkg::POS_HDR_SECOND: begin
            frame_pos = (b == iafp_pkg::HDR_SECOND) ? iafp_pkg::POS_SKIP_0
                                                    : iafp_pkg::POS_HDR_FIRST;
            return 1'b0;
         end
         iafp_pkg::POS_YAW_LOW: begin
            low_byte  = b;
            frame_pos = iafp_pkg::POS_YAW_HIGH;
            return 1'b0;
         end
         iafp_pkg::POS_YAW_HIGH: begin
            frame_pos = iafp_pkg::POS_HDR_FIRST;
            yaw       = {b, low_byte};
            yaw_sum   = yaw_sum - yaw_window[win_idx] + yaw;
            yaw_window[win_idx] = yaw;
            win_idx   = win_idx + 1'b1;
            shifted   = yaw_sum >>> iafp_pkg::DEPTH_LOG2;
            res.yaw_latest = yaw;
            res.yaw_mean   = shifted[iafp_pkg::YAW_WIDTH-1:0];
            return 1'b1;
         end
         default: begin
            frame_pos = iafp_pkg::frame_pos_type'(frame_pos + 3'd1);
            return 1'b0;
         end
      endcase
   endfunction

   // one byte transaction; bursts of back-to-back bytes, mostly with idle gaps between
   task automatic send_byte(input logic [7:0] b, input logic has_exp,
                            input yaw_result_type exp_res);
      int             gap;
      yaw_result_type pred;
      bit             got;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      got = parse_byte(b, pred);
      if (has_exp) expected_results.push_back(exp_res);
      else if (got) expected_results.push_back(pred);
   endtask

   initial begin
      int          kind;
      int          n;
      logic [15:0] yaw_word;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIR; i++)
         send_byte(DIR_ROWS[i].rx, DIR_ROWS[i].has_exp, DIR_ROWS[i].res);

      while (bytes_sent < NUM_DIR + RANDOM_BYTES) begin
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            case ($urandom_range(0, 7))
               0:       yaw_word = 16'h7FFF;
               1:       yaw_word = 16'h8000;
               2:       yaw_word = 16'hFFFF;
               3:       yaw_word = 16'h0000;
               default: yaw_word = 16'($urandom);
            endcase
            send_byte(iafp_pkg::HDR_FIRST, 1'b0, '0);
            send_byte(iafp_pkg::HDR_SECOND, 1'b0, '0);
            repeat (4) send_byte(8'($urandom), 1'b0, '0);
            send_byte(yaw_word[7:0], 1'b0, '0);
            send_byte(yaw_word[15:8], 1'b0, '0);
         end else if (kind < 9) begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom), 1'b0, '0);
         end else begin
            send_byte(iafp_pkg::HDR_FIRST, 1'b0, '0);
            send_byte($urandom_range(0, 1) ? iafp_pkg::HDR_FIRST : 8'($urandom),
                      1'b0, '0);
         end
      end
      req_tvalid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // receiver: random ready patterns, plus one long hold-off to back up the core
   initial begin
      int mode;
      int len;
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && bytes_sent >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(8, 80);
            repeat (len) begin
               case (mode)
                  0:       rsp_tready <= 1'b1;
                  1:       rsp_tready <= 1'($urandom_range(0, 1));
                  default: rsp_tready <= ($urandom_range(0, 3) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      yaw_result_type got;
      yaw_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result transaction, actual %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (got.yaw_latest !== want.yaw_latest) begin
               $display("%0t: yaw_latest expected %0d actual %0d",
                        $time, want.yaw_latest, got.yaw_latest);
               error_count++;
            end
            if (got.yaw_mean !== want.yaw_mean) begin
               $display("%0t: yaw_mean expected %0d actual %0d",
                        $time, want.yaw_mean, got.yaw_mean);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

endmodule
